### hdl/tkd_pkg.sv
// ----------------------------------------------------------------------------
// tkd_pkg
// Shared types and constants for the terminal key decoder with cursor.
// ----------------------------------------------------------------------------
package tkd_pkg;

	localparam int KeyBits = 9;
	localparam int WinBits = 11;

	// received byte values with a meaning to the parser
	localparam logic [7:0] BYTE_ESC    = 8'h1B;
	localparam logic [7:0] BYTE_LBRACK = 8'h5B;
	localparam logic [7:0] BYTE_O      = 8'h4F;
	localparam logic [7:0] BYTE_TILDE  = 8'h7E;

	// key codes
	localparam logic [KeyBits-1:0] KEY_ESC   = 9'd27;
	localparam logic [KeyBits-1:0] KEY_QUIT  = 9'h011;
	localparam logic [KeyBits-1:0] KEY_LEFT  = 9'd256;
	localparam logic [KeyBits-1:0] KEY_RIGHT = 9'd257;
	localparam logic [KeyBits-1:0] KEY_UP    = 9'd258;
	localparam logic [KeyBits-1:0] KEY_DOWN  = 9'd259;
	localparam logic [KeyBits-1:0] KEY_DEL   = 9'd260;
	localparam logic [KeyBits-1:0] KEY_HOME  = 9'd261;
	localparam logic [KeyBits-1:0] KEY_END   = 9'd262;
	localparam logic [KeyBits-1:0] KEY_PGUP  = 9'd263;
	localparam logic [KeyBits-1:0] KEY_PGDN  = 9'd264;

	// configuration register indexes
	localparam logic REG_WINDOW_ROWS = 1'b0;
	localparam logic REG_WINDOW_COLS = 1'b1;

	localparam logic [WinBits-1:0] WINDOW_ROWS_RESET = 11'd24;
	localparam logic [WinBits-1:0] WINDOW_COLS_RESET = 11'd80;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_ESC   = 2'd1,
		PH_PAIR  = 2'd2,
		PH_DIGIT = 2'd3
	} phase_t;

	// decoded key handed from parser to cursor unit
	typedef struct packed {
		logic               valid;
		logic [KeyBits-1:0] code;
	} key_t;

endpackage

### hdl/tkd_if.sv
// ----------------------------------------------------------------------------
// tkd_evt_if / tkd_key_if
// Valid/ready channels for terminal events in and decoded keys out.
// ----------------------------------------------------------------------------
interface tkd_evt_if;
	logic       valid;
	logic       ready;
	logic       event_kind;
	logic [7:0] rx_byte;

	modport source (output valid, output event_kind, output rx_byte, input ready);
	modport sink   (input valid, input event_kind, input rx_byte, output ready);
endinterface

interface tkd_key_if #(parameter int COORD_BITS = 10);
	logic                  valid;
	logic                  ready;
	logic [8:0]            key_code;
	logic                  quit;
	logic [COORD_BITS-1:0] cursor_x;
	logic [COORD_BITS-1:0] cursor_y;

	modport source (output valid, output key_code, output quit, output cursor_x,
		output cursor_y, input ready);
	modport sink   (input valid, input key_code, input quit, input cursor_x,
		input cursor_y, output ready);
endinterface

### hdl/tkd_parser.sv
// ----------------------------------------------------------------------------
// tkd_parser
// Escape sequence parser: turns bytes and timeouts into key codes.
// ----------------------------------------------------------------------------
module tkd_parser (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          fire,
	input  logic          event_kind,
	input  logic [7:0]    rx_byte,
	output tkd_pkg::key_t key
);

	tkd_pkg::phase_t phase_q, phase_d;
	logic [7:0]      first_q, first_d;
	logic [7:0]      digit_q, digit_d;

	function automatic logic [tkd_pkg::KeyBits-1:0] decode_pair(
		input logic [7:0] a, input logic [7:0] b);
		logic [tkd_pkg::KeyBits-1:0] k;
		k = tkd_pkg::KEY_ESC;
		if (a == tkd_pkg::BYTE_LBRACK) begin
			unique case (b)
				8'h41:   k = tkd_pkg::KEY_UP;
				8'h42:   k = tkd_pkg::KEY_DOWN;
				8'h43:   k = tkd_pkg::KEY_RIGHT;
				8'h44:   k = tkd_pkg::KEY_LEFT;
				8'h48:   k = tkd_pkg::KEY_HOME;
				8'h46:   k = tkd_pkg::KEY_END;
				default: k = tkd_pkg::KEY_ESC;
			endcase
		end else if (a == tkd_pkg::BYTE_O) begin
			if (b == 8'h48) k = tkd_pkg::KEY_HOME;
			else if (b == 8'h46) k = tkd_pkg::KEY_END;
		end
		return k;
	endfunction

	function automatic logic [tkd_pkg::KeyBits-1:0] decode_tilde(input logic [7:0] d);
		logic [tkd_pkg::KeyBits-1:0] k;
		unique case (d)
			8'h31:   k = tkd_pkg::KEY_HOME;
			8'h33:   k = tkd_pkg::KEY_DEL;
			8'h34:   k = tkd_pkg::KEY_END;
			8'h35:   k = tkd_pkg::KEY_PGUP;
			8'h36:   k = tkd_pkg::KEY_PGDN;
			8'h37:   k = tkd_pkg::KEY_HOME;
			8'h38:   k = tkd_pkg::KEY_END;
			default: k = tkd_pkg::KEY_ESC;
		endcase
		return k;
	endfunction

	always_comb begin
		phase_d   = phase_q;
		first_d   = first_q;
		digit_d   = digit_q;
		key.valid = 1'b0;
		key.code  = {1'b0, rx_byte};
		if (event_kind) begin
			// timeout: a pending sequence collapses to a bare escape
			if (phase_q != tkd_pkg::PH_IDLE) begin
				key.valid = 1'b1;
				key.code  = tkd_pkg::KEY_ESC;
				phase_d   = tkd_pkg::PH_IDLE;
			end
		end else begin
			unique case (phase_q)
				tkd_pkg::PH_IDLE: begin
					if (rx_byte == tkd_pkg::BYTE_ESC) phase_d = tkd_pkg::PH_ESC;
					else key.valid = 1'b1;
				end
				tkd_pkg::PH_ESC: begin
					first_d = rx_byte;
					phase_d = tkd_pkg::PH_PAIR;
				end
				tkd_pkg::PH_PAIR: begin
					if (first_q == tkd_pkg::BYTE_LBRACK && rx_byte >= 8'h30 && rx_byte <= 8'h39)
					begin
						digit_d = rx_byte;
						phase_d = tkd_pkg::PH_DIGIT;
					end else begin
						key.valid = 1'b1;
						key.code  = decode_pair(first_q, rx_byte);
						phase_d   = tkd_pkg::PH_IDLE;
					end
				end
				tkd_pkg::PH_DIGIT: begin
					key.valid = 1'b1;
					key.code  = (rx_byte == tkd_pkg::BYTE_TILDE) ? decode_tilde(digit_q)
						: tkd_pkg::KEY_ESC;
					phase_d   = tkd_pkg::PH_IDLE;
				end
				default: phase_d = tkd_pkg::PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tkd_pkg::PH_IDLE;
			first_q <= 8'd0;
			digit_q <= 8'd0;
		end else if (fire) begin
			phase_q <= phase_d;
			first_q <= first_d;
			digit_q <= digit_d;
		end
	end

endmodule

### hdl/tkd_cursor.sv
// ----------------------------------------------------------------------------
// tkd_cursor
// Window size registers and cursor position, moved by decoded keys.
// ----------------------------------------------------------------------------
module tkd_cursor #(
	parameter int COORD_BITS = 10
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [tkd_pkg::WinBits-1:0] cfg_data,
	input  logic                        fire,
	input  tkd_pkg::key_t               key,
	output logic                        quit,
	output logic [COORD_BITS-1:0]       col_next,
	output logic [COORD_BITS-1:0]       row_next
);

	localparam int LimBits = 17;
	localparam logic [LimBits-1:0] WinLim = LimBits'(1) << COORD_BITS;

	logic [tkd_pkg::WinBits-1:0] rows_q, cols_q;
	logic [COORD_BITS-1:0]       col_q, row_q;
	logic [COORD_BITS-1:0]       last_col, last_row;

	// last usable index, with a zero size acting as one and oversize clamped
	function automatic logic [COORD_BITS-1:0] last_index(input logic [tkd_pkg::WinBits-1:0] v);
		logic [LimBits-1:0] ve;
		logic [LimBits-1:0] vm1;
		logic [COORD_BITS-1:0] r;
		ve  = LimBits'(v);
		vm1 = ve - LimBits'(1);
		if (ve == '0) r = '0;
		else if (ve > WinLim) r = '1;
		else r = vm1[COORD_BITS-1:0];
		return r;
	endfunction

	assign last_col = last_index(cols_q);
	assign last_row = last_index(rows_q);

	always_comb begin
		col_next = col_q;
		row_next = row_q;
		quit     = 1'b0;
		unique case (key.code)
			tkd_pkg::KEY_QUIT:  quit = 1'b1;
			tkd_pkg::KEY_LEFT:  if (col_q != '0) col_next = col_q - COORD_BITS'(1);
			tkd_pkg::KEY_RIGHT: col_next = (col_q >= last_col) ? last_col
				: col_q + COORD_BITS'(1);
			tkd_pkg::KEY_UP:    if (row_q != '0) row_next = row_q - COORD_BITS'(1);
			tkd_pkg::KEY_DOWN:  row_next = (row_q >= last_row) ? last_row
				: row_q + COORD_BITS'(1);
			tkd_pkg::KEY_HOME:  col_next = '0;
			tkd_pkg::KEY_END:   col_next = last_col;
			tkd_pkg::KEY_PGUP:  row_next = '0;
			tkd_pkg::KEY_PGDN:  row_next = last_row;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= tkd_pkg::WINDOW_ROWS_RESET;
			cols_q <= tkd_pkg::WINDOW_COLS_RESET;
		end else if (cfg_we) begin
			if (cfg_index == tkd_pkg::REG_WINDOW_ROWS) rows_q <= cfg_data;
			if (cfg_index == tkd_pkg::REG_WINDOW_COLS) cols_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (fire && key.valid) begin
			col_q <= col_next;
			row_q <= row_next;
		end
	end

endmodule

### hdl/terminal_key_decoder_cursor.sv
// ----------------------------------------------------------------------------
// terminal_key_decoder_cursor
// Decodes terminal escape sequences into keys and tracks a cursor.
// ----------------------------------------------------------------------------
// an accepted event goes to stage 1, then its key to the result register
// one event per cycle unless output stalls; decode, cursor update fit one stage
// an event that completes no key (ESC, sequence bytes, idle timeout) is dropped
// reset: parser idle, cursor at 0,0, window 24 rows by 80 columns
module terminal_key_decoder_cursor #(
	parameter int COORD_BITS = 10
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [tkd_pkg::WinBits-1:0] cfg_data,
	tkd_evt_if.sink                     evt,
	tkd_key_if.source                   key
);

	logic                  valid_s1;
	logic                  kind_s1;
	logic [7:0]            byte_s1;
	logic                  fire_s1;
	tkd_pkg::key_t         dec;
	logic                  quit_c;
	logic [COORD_BITS-1:0] col_c, row_c;

	logic                  out_valid_q;
	logic [8:0]            code_q;
	logic                  quit_q;
	logic [COORD_BITS-1:0] col_q, row_q;

	// stage 1 retires when the result register is free or draining
	assign fire_s1   = valid_s1 && (!out_valid_q || key.ready);
	assign evt.ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (evt.ready) valid_s1 <= evt.valid;
	end

	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			kind_s1 <= evt.event_kind;
			byte_s1 <= evt.rx_byte;
		end
	end

	tkd_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire_s1),
		.event_kind (kind_s1),
		.rx_byte    (byte_s1),
		.key        (dec)
	);

	tkd_cursor #(.COORD_BITS(COORD_BITS)) u_cursor (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fire      (fire_s1),
		.key       (dec),
		.quit      (quit_c),
		.col_next  (col_c),
		.row_next  (row_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (fire_s1 && dec.valid) out_valid_q <= 1'b1;
		else if (key.ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && dec.valid) begin
			code_q <= dec.code;
			quit_q <= quit_c;
			col_q  <= col_c;
			row_q  <= row_c;
		end
	end

	assign key.valid    = out_valid_q;
	assign key.key_code = code_q;
	assign key.quit     = quit_q;
	assign key.cursor_x = col_q;
	assign key.cursor_y = row_q;

	// a new transaction never overwrites a result still waiting downstream
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !key.ready) |-> !fire_s1)
		else $error("result overwritten while stalled");

	a_quit_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (quit_q == (code_q == tkd_pkg::KEY_QUIT)))
		else $error("quit flag does not match key code");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (code_q <= tkd_pkg::KEY_PGDN))
		else $error("key code out of range");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(fire_s1))
		else $error("result without a retired event");

endmodule
